// ===== design/rsc_pkg.sv =====
// Shared types and constants of the reset sequencer change logger.
`default_nettype none

package rsc_pkg;

    localparam int CFG_WIDTH        = 40;
    localparam int CFG_INDEX_WIDTH  = 1;
    localparam int CMD_WIDTH        = 2;
    localparam int LINES_WIDTH      = 4;
    localparam int INDEX_WIDTH      = 13;
    localparam int COUNT_OUT_WIDTH  = 14;
    localparam int ENTRY_TIME_WIDTH = 40;
    localparam int VALUE_WIDTH      = 5;
    localparam int PHASE_WIDTH      = 3;

    localparam logic [CMD_WIDTH-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_START = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RESET_HOLD = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMEOUT    = 1'b1;

    localparam logic [CFG_WIDTH-1:0] RESET_HOLD_RESET = 40'd0;
    localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET    = 40'd10000000000;

    // clock locked, mmcm locked, calibration complete; reset and sync reset low
    localparam logic [VALUE_WIDTH-1:0] COMPLETE_PATTERN = 5'b01110;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_START,
        OP_READ,
        OP_NOP
    } op_t;

    typedef enum logic [PHASE_WIDTH-1:0] {
        PH_IDLE    = 3'd0,
        PH_ASSERT  = 3'd1,
        PH_WAIT    = 3'd2,
        PH_DONE    = 3'd3,
        PH_TIMEOUT = 3'd4
    } phase_t;

    typedef struct packed {
        op_t                    op;
        logic [LINES_WIDTH-1:0] lines;
        logic [INDEX_WIDTH-1:0] index;
    } request_t;

endpackage

`default_nettype wire

// ===== design/rsc_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none

module rsc_ram #(
    parameter int WIDTH = 45,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== design/rsc_front.sv =====
// Front end: decode input commands and queue them for the sequencer.
`default_nettype none

module rsc_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [rsc_pkg::CMD_WIDTH-1:0]    cmd,
    input  wire logic [rsc_pkg::LINES_WIDTH-1:0]  status_lines,
    input  wire logic [rsc_pkg::INDEX_WIDTH-1:0]  read_index,
    output logic                                  q_valid,
    output rsc_pkg::request_t                     q_req,
    input  wire logic                             q_ready
);

    localparam int QDEPTH = 2;

    rsc_pkg::request_t entry_reg [QDEPTH];
    rsc_pkg::request_t decoded;
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        fill_reg, fill_next;
    logic              push, pop;

    always_comb
    begin
        decoded.lines = status_lines;
        decoded.index = read_index;
        unique case (cmd)
            rsc_pkg::CMD_TICK:  decoded.op = rsc_pkg::OP_TICK;
            rsc_pkg::CMD_START: decoded.op = rsc_pkg::OP_START;
            rsc_pkg::CMD_READ:  decoded.op = rsc_pkg::OP_READ;
            default:            decoded.op = rsc_pkg::OP_NOP;
        endcase
    end

    assign in_ready = (fill_reg != 2'(QDEPTH));
    assign q_valid  = (fill_reg != 2'd0);
    assign q_req    = entry_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

// ===== design/rsc_back.sv =====
// Back end: reset sequence, change log memory and result register.
`default_nettype none

module rsc_back #(
    parameter int LOG_DEPTH  = 8192,
    parameter int TIME_WIDTH = 40
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [rsc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [rsc_pkg::CFG_WIDTH-1:0]        cfg_wdata,
    input  wire logic                                 q_valid,
    input  wire rsc_pkg::request_t                    q_req,
    output logic                                      q_ready,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      reset_drive,
    output logic [rsc_pkg::PHASE_WIDTH-1:0]           phase,
    output logic [rsc_pkg::COUNT_OUT_WIDTH-1:0]       entries_logged,
    output logic [rsc_pkg::ENTRY_TIME_WIDTH-1:0]      entry_time,
    output logic [rsc_pkg::VALUE_WIDTH-1:0]           entry_value
);

    localparam int VW    = rsc_pkg::VALUE_WIDTH;
    localparam int AW    = $clog2(LOG_DEPTH);
    localparam int CW    = $clog2(LOG_DEPTH + 1);
    localparam int CMPW  = (TIME_WIDTH > rsc_pkg::CFG_WIDTH) ? TIME_WIDTH : rsc_pkg::CFG_WIDTH;
    localparam int IW    = (rsc_pkg::INDEX_WIDTH > CW) ? rsc_pkg::INDEX_WIDTH : CW;
    localparam int WORDW = TIME_WIDTH + VW;

    typedef enum logic {
        S_EXEC,
        S_FIN
    } seq_state_t;

    seq_state_t                         state_reg, state_next;
    rsc_pkg::phase_t                    phase_reg, phase_next;
    logic                               level_reg, level_next;
    logic [TIME_WIDTH-1:0]              elapsed_reg, elapsed_next;
    logic [TIME_WIDTH-1:0]              release_reg, release_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [VW-1:0]                      last_reg, last_next;
    logic [rsc_pkg::CFG_WIDTH-1:0]      hold_reg, hold_next;
    logic [rsc_pkg::CFG_WIDTH-1:0]      timeout_reg, timeout_next;
    logic                               fin_read_reg, fin_read_next;
    logic                               hit_reg, hit_next;
    logic [AW-1:0]                      wr2_addr_reg, wr2_addr_next;
    logic [WORDW-1:0]                   wr2_data_reg, wr2_data_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               drive_reg, drive_next;
    logic [rsc_pkg::PHASE_WIDTH-1:0]    ophase_reg, ophase_next;
    logic [rsc_pkg::COUNT_OUT_WIDTH-1:0] entries_reg, entries_next;
    logic [rsc_pkg::ENTRY_TIME_WIDTH-1:0] etime_reg, etime_next;
    logic [VW-1:0]                      evalue_reg, evalue_next;

    logic                               go;
    logic [TIME_WIDTH-1:0]              elapsed_inc;
    logic [TIME_WIDTH-1:0]              wtime;
    logic [CW-1:0]                      base_cnt, c1;
    logic [VW-1:0]                      pat1, pat2, l1;
    logic                               do1, do2, a1, a2;
    logic                               is_read, need_fin;
    logic                               mem_we;
    logic [AW-1:0]                      mem_addr;
    logic [WORDW-1:0]                   mem_wdata, mem_rdata;

    function automatic logic want_append(
        input logic [CW-1:0] cnt,
        input logic [VW-1:0] last,
        input logic [VW-1:0] pat
    );
        return (cnt == '0) || ((cnt < CW'(LOG_DEPTH)) && (last != pat));
    endfunction

    assign go      = (state_reg == S_EXEC) && q_valid && (!out_valid_reg || out_ready);
    assign q_ready = go;

    always_comb
    begin
        elapsed_inc = (elapsed_reg == {TIME_WIDTH{1'b1}}) ? elapsed_reg
                                                          : elapsed_reg + TIME_WIDTH'(1);
        phase_next   = phase_reg;
        level_next   = level_reg;
        elapsed_next = elapsed_reg;
        release_next = release_reg;
        base_cnt     = count_reg;
        wtime        = elapsed_reg;
        pat1         = '0;
        pat2         = '0;
        do1          = 1'b0;
        do2          = 1'b0;
        is_read      = 1'b0;

        unique case (q_req.op)
            rsc_pkg::OP_START:
            begin
                if (phase_reg != rsc_pkg::PH_ASSERT && phase_reg != rsc_pkg::PH_WAIT)
                begin
                    // clear the log, sample with reset low and then high
                    base_cnt     = '0;
                    elapsed_next = '0;
                    release_next = '0;
                    wtime        = '0;
                    pat1         = {q_req.lines, 1'b0};
                    pat2         = {q_req.lines, 1'b1};
                    do1          = 1'b1;
                    do2          = 1'b1;
                    level_next   = 1'b1;
                    phase_next   = rsc_pkg::PH_ASSERT;
                end
            end
            rsc_pkg::OP_TICK:
            begin
                if (phase_reg == rsc_pkg::PH_ASSERT)
                begin
                    elapsed_next = elapsed_inc;
                    wtime        = elapsed_inc;
                    pat1         = {q_req.lines, level_reg};
                    do1          = 1'b1;
                    if (CMPW'(elapsed_inc) >= CMPW'(hold_reg))
                    begin
                        // release: log the sample again with reset low
                        pat2         = {q_req.lines, 1'b0};
                        do2          = 1'b1;
                        level_next   = 1'b0;
                        release_next = elapsed_inc;
                        phase_next   = rsc_pkg::PH_WAIT;
                    end
                end
                else if (phase_reg == rsc_pkg::PH_WAIT)
                begin
                    elapsed_next = elapsed_inc;
                    wtime        = elapsed_inc;
                    pat1         = {q_req.lines, level_reg};
                    do1          = 1'b1;
                    if (CMPW'(elapsed_inc - release_reg) >= CMPW'(timeout_reg))
                    begin
                        phase_next = rsc_pkg::PH_TIMEOUT;
                    end
                    else if (pat1 == rsc_pkg::COMPLETE_PATTERN)
                    begin
                        phase_next = rsc_pkg::PH_DONE;
                    end
                end
            end
            rsc_pkg::OP_READ:
            begin
                is_read = 1'b1;
            end
            default:
            begin
            end
        endcase

        a1         = do1 && want_append(base_cnt, last_reg, pat1);
        c1         = base_cnt + CW'(a1);
        l1         = a1 ? pat1 : last_reg;
        a2         = do2 && want_append(c1, l1, pat2);
        count_next = c1 + CW'(a2);
        last_next  = a2 ? pat2 : l1;
        need_fin   = (a1 && a2) || is_read;
    end

    // memory port: first append or read issue in EXEC, second append in FIN
    always_comb
    begin
        if (state_reg == S_FIN)
        begin
            mem_we    = !fin_read_reg;
            mem_addr  = wr2_addr_reg;
            mem_wdata = wr2_data_reg;
        end
        else if (is_read)
        begin
            mem_we    = 1'b0;
            mem_addr  = AW'(q_req.index);
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = go && (a1 || a2);
            mem_addr  = a1 ? base_cnt[AW-1:0] : c1[AW-1:0];
            mem_wdata = a1 ? {wtime, pat1} : {wtime, pat2};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        hold_next      = hold_reg;
        timeout_next   = timeout_reg;
        fin_read_next  = fin_read_reg;
        hit_next       = hit_reg;
        wr2_addr_next  = wr2_addr_reg;
        wr2_data_next  = wr2_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        drive_next     = drive_reg;
        ophase_next    = ophase_reg;
        entries_next   = entries_reg;
        etime_next     = etime_reg;
        evalue_next    = evalue_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                rsc_pkg::CFG_RESET_HOLD: hold_next    = cfg_wdata;
                rsc_pkg::CFG_TIMEOUT:    timeout_next = cfg_wdata;
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_EXEC:
            begin
                if (go)
                begin
                    drive_next     = level_next;
                    ophase_next    = phase_next;
                    entries_next   = rsc_pkg::COUNT_OUT_WIDTH'(count_next);
                    etime_next     = '0;
                    evalue_next    = '0;
                    out_valid_next = !need_fin;
                    fin_read_next  = is_read;
                    hit_next       = IW'(q_req.index) < IW'(count_reg);
                    wr2_addr_next  = c1[AW-1:0];
                    wr2_data_next  = {wtime, pat2};
                    if (need_fin)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (fin_read_reg && hit_reg)
                begin
                    etime_next  = rsc_pkg::ENTRY_TIME_WIDTH'(mem_rdata[WORDW-1:VW]);
                    evalue_next = mem_rdata[VW-1:0];
                end
                out_valid_next = 1'b1;
                state_next     = S_EXEC;
            end
            default:
            begin
                state_next = S_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_EXEC;
            phase_reg     <= rsc_pkg::PH_IDLE;
            level_reg     <= 1'b0;
            elapsed_reg   <= '0;
            release_reg   <= '0;
            count_reg     <= '0;
            last_reg      <= '0;
            hold_reg      <= rsc_pkg::RESET_HOLD_RESET;
            timeout_reg   <= rsc_pkg::TIMEOUT_RESET;
            fin_read_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            drive_reg     <= 1'b0;
            ophase_reg    <= '0;
            entries_reg   <= '0;
            etime_reg     <= '0;
            evalue_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            if (go)
            begin
                phase_reg   <= phase_next;
                level_reg   <= level_next;
                elapsed_reg <= elapsed_next;
                release_reg <= release_next;
                count_reg   <= count_next;
                last_reg    <= last_next;
            end
            hold_reg      <= hold_next;
            timeout_reg   <= timeout_next;
            fin_read_reg  <= fin_read_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            drive_reg     <= drive_next;
            ophase_reg    <= ophase_next;
            entries_reg   <= entries_next;
            etime_reg     <= etime_next;
            evalue_reg    <= evalue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr2_addr_reg <= wr2_addr_next;
        wr2_data_reg <= wr2_data_next;
    end

    rsc_ram #(
        .WIDTH (WORDW),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign out_valid      = out_valid_reg;
    assign reset_drive    = drive_reg;
    assign phase          = ophase_reg;
    assign entries_logged = entries_reg;
    assign entry_time     = etime_reg;
    assign entry_value    = evalue_reg;

endmodule

`default_nettype wire

// ===== design/reset_sequencer_change_logger_core.sv =====
// Top level of the reset sequencer with timestamped status change log.
//
// Requests enter on in_valid/in_ready with cmd, status_lines and read_index;
// each request yields exactly one result on out_valid/out_ready carrying
// reset_drive, phase, entries_logged, entry_time and entry_value as they
// stand after that request. Registers are written through cfg_we/cfg_index/
// cfg_wdata, by the user only while no request is in flight; the block does
// not enforce it. A two-entry request queue sits between the decoder and the
// sequencer. The sequencer owns one single-port log RAM, so a request that
// appends two entries (a start, or a reset release with changed lines) or
// reads an entry (registered RAM read) passes through FIN after EXEC; any
// other request finishes in EXEC. A new request is taken only while the
// result register is empty or its result is being taken.
// When the receiver stalls, the result holds, the sequencer halts and the
// queue fills; in_ready drops once two requests are queued.
// Reset empties the queue, clears the result register, sets phase idle,
// reset_drive low, the log empty and both registers to their defaults.
// No clearing pass is needed: entries beyond the log count are never read.
`default_nettype none

module reset_sequencer_change_logger_core #(
    parameter int LOG_DEPTH  = 8192,
    parameter int TIME_WIDTH = 40
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [rsc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [rsc_pkg::CFG_WIDTH-1:0]        cfg_wdata,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [rsc_pkg::CMD_WIDTH-1:0]        cmd,
    input  wire logic [rsc_pkg::LINES_WIDTH-1:0]      status_lines,
    input  wire logic [rsc_pkg::INDEX_WIDTH-1:0]      read_index,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      reset_drive,
    output logic [rsc_pkg::PHASE_WIDTH-1:0]           phase,
    output logic [rsc_pkg::COUNT_OUT_WIDTH-1:0]       entries_logged,
    output logic [rsc_pkg::ENTRY_TIME_WIDTH-1:0]      entry_time,
    output logic [rsc_pkg::VALUE_WIDTH-1:0]           entry_value
);

    logic              q_valid;
    logic              q_ready;
    rsc_pkg::request_t q_req;

    rsc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .status_lines (status_lines),
        .read_index   (read_index),
        .q_valid      (q_valid),
        .q_req        (q_req),
        .q_ready      (q_ready)
    );

    rsc_back #(
        .LOG_DEPTH  (LOG_DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .q_valid        (q_valid),
        .q_req          (q_req),
        .q_ready        (q_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reset_drive    (reset_drive),
        .phase          (phase),
        .entries_logged (entries_logged),
        .entry_time     (entry_time),
        .entry_value    (entry_value)
    );

endmodule

`default_nettype wire

// ===== verif/rsc_change_log_checker.sv =====
// Checker for the reset sequencer change logger: predicts every result and compares it.
module rsc_change_log_checker #(
    parameter int LOG_DEPTH = 8192
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [rsc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [rsc_pkg::CFG_WIDTH-1:0]       cfg_wdata,
    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire logic [rsc_pkg::CMD_WIDTH-1:0]       cmd,
    input  wire logic [rsc_pkg::LINES_WIDTH-1:0]     status_lines,
    input  wire logic [rsc_pkg::INDEX_WIDTH-1:0]     read_index,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic                                reset_drive,
    input  wire logic [rsc_pkg::PHASE_WIDTH-1:0]     phase,
    input  wire logic [rsc_pkg::COUNT_OUT_WIDTH-1:0] entries_logged,
    input  wire logic [rsc_pkg::ENTRY_TIME_WIDTH-1:0] entry_time,
    input  wire logic [rsc_pkg::VALUE_WIDTH-1:0]     entry_value,
    output int                                       mismatches,
    output int                                       reports_due
);
    import rsc_pkg::*;

    localparam logic [ENTRY_TIME_WIDTH-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic                        drive;
        phase_t                      ph;
        logic [COUNT_OUT_WIDTH-1:0]  count;
        logic [ENTRY_TIME_WIDTH-1:0] etime;
        logic [VALUE_WIDTH-1:0]      evalue;
    } status_report_t;

    logic [CFG_WIDTH-1:0]        hold_ticks;
    logic [CFG_WIDTH-1:0]        timeout_ticks;
    phase_t                      seq_phase;
    logic                        reset_level;
    logic [ENTRY_TIME_WIDTH-1:0] elapsed;
    logic [ENTRY_TIME_WIDTH-1:0] release_at;
    int                          log_count;
    logic [ENTRY_TIME_WIDTH-1:0] log_time [LOG_DEPTH];
    logic [VALUE_WIDTH-1:0]      log_value [LOG_DEPTH];
    status_report_t              status_reports_q[$];
    int                          errors;

    // append only on a change, or into an empty log; drop once full
    task automatic log_sample(input logic [VALUE_WIDTH-1:0] pattern);
        if (log_count == 0 ||
            (log_count < LOG_DEPTH && log_value[log_count-1] != pattern))
        begin
            log_time[log_count]  = elapsed;
            log_value[log_count] = pattern;
            log_count++;
        end
    endtask

    task automatic step_sequencer(
        input  logic [CMD_WIDTH-1:0]   op,
        input  logic [LINES_WIDTH-1:0] lines,
        input  logic [INDEX_WIDTH-1:0] idx,
        output status_report_t         report
    );
        logic [VALUE_WIDTH-1:0] pattern;
        report = '0;
        case (op_t'(op))
            OP_START:
            begin
                if (seq_phase != PH_ASSERT && seq_phase != PH_WAIT)
                begin
                    log_count   = 0;
                    elapsed     = '0;
                    release_at  = '0;
                    reset_level = 1'b0;
                    log_sample({lines, 1'b0});
                    reset_level = 1'b1;
                    log_sample({lines, 1'b1});
                    seq_phase   = PH_ASSERT;
                end
            end
            OP_TICK:
            begin
                if ((seq_phase == PH_ASSERT || seq_phase == PH_WAIT) && elapsed != TIME_MAX)
                    elapsed++;
                if (seq_phase == PH_ASSERT)
                begin
                    log_sample({lines, reset_level});
                    if (elapsed >= hold_ticks)
                    begin
                        // release: log the low level in the same request
                        reset_level = 1'b0;
                        log_sample({lines, 1'b0});
                        release_at = elapsed;
                        seq_phase  = PH_WAIT;
                    end
                end
                else if (seq_phase == PH_WAIT)
                begin
                    pattern = {lines, reset_level};
                    log_sample(pattern);
                    if (elapsed - release_at >= timeout_ticks)
                        seq_phase = PH_TIMEOUT;
                    else if (pattern == COMPLETE_PATTERN)
                        seq_phase = PH_DONE;
                end
            end
            OP_READ:
            begin
                if (int'(idx) < log_count)
                begin
                    report.etime  = log_time[idx];
                    report.evalue = log_value[idx];
                end
            end
            default: ;
        endcase
        report.drive = reset_level;
        report.ph    = seq_phase;
        report.count = COUNT_OUT_WIDTH'(log_count);
    endtask

    task automatic flag(input string field, input logic [63:0] want, input logic [63:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        status_report_t want;
        status_report_t predicted;
        if (!rst_n)
        begin
            hold_ticks    = RESET_HOLD_RESET;
            timeout_ticks = TIMEOUT_RESET;
            seq_phase     = PH_IDLE;
            reset_level   = 1'b0;
            elapsed       = '0;
            release_at    = '0;
            log_count     = 0;
            status_reports_q.delete();
            errors        = 0;
            mismatches  <= 0;
            reports_due <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RESET_HOLD: hold_ticks    = cfg_wdata;
                    CFG_TIMEOUT:    timeout_ticks = cfg_wdata;
                    default: ;
                endcase
            end

            // results come back only after their requests pass the queue registers: compare before predicting
            if (out_valid && out_ready)
            begin
                if (status_reports_q.size() == 0)
                begin
                    $display("%0t: result with no request pending, actual phase %0d count %0d",
                             $time, phase, entries_logged);
                    errors++;
                end
                else
                begin
                    want = status_reports_q.pop_front();
                    if (reset_drive !== want.drive)
                        flag("reset_drive", want.drive, reset_drive);
                    if (phase !== want.ph)
                        flag("phase", want.ph, phase);
                    if (entries_logged !== want.count)
                        flag("entries_logged", want.count, entries_logged);
                    if (entry_time !== want.etime)
                        flag("entry_time", want.etime, entry_time);
                    if (entry_value !== want.evalue)
                        flag("entry_value", want.evalue, entry_value);
                end
            end

            if (in_valid && in_ready)
            begin
                step_sequencer(cmd, status_lines, read_index, predicted);
                status_reports_q.push_back(predicted);
            end

            mismatches  <= errors;
            reports_due <= status_reports_q.size();
        end
    end

endmodule

// ===== verif/reset_sequencer_change_logger_core_tb.sv =====
// Testbench top: drives requests, register writes and stalls, and gives the verdict.
module reset_sequencer_change_logger_core_tb;
    import rsc_pkg::*;

    localparam logic [CFG_WIDTH-1:0]   CFG_MAX        = '1;
    // with the reset low this gives the complete pattern
    localparam logic [LINES_WIDTH-1:0] LINES_READY    = 4'h7;
    localparam int                     TOGGLE_TICKS   = 200;
    localparam int                     RANDOM_PHASES  = 12;
    localparam int                     PHASE_REQUESTS = 130;

    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_RUNS   = 3;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        cfg_we       = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]  cfg_index    = '0;
    logic [CFG_WIDTH-1:0]        cfg_wdata    = '0;
    logic                        in_valid     = 1'b0;
    logic [CMD_WIDTH-1:0]        cmd          = '0;
    logic [LINES_WIDTH-1:0]      status_lines = '0;
    logic [INDEX_WIDTH-1:0]      read_index   = '0;
    logic                        out_ready    = 1'b0;
    logic                        in_ready;
    logic                        out_valid;
    logic                        reset_drive;
    logic [PHASE_WIDTH-1:0]      phase;
    logic [COUNT_OUT_WIDTH-1:0]  entries_logged;
    logic [ENTRY_TIME_WIDTH-1:0] entry_time;
    logic [VALUE_WIDTH-1:0]      entry_value;
    int                          mismatches;
    int                          reports_due;

    int                          burst_left = 0;
    logic [LINES_WIDTH-1:0]      last_lines = '0;
    int                          stall_mode = RX_OPEN;
    int                          mode_left  = 0;
    int                          run_left   = 0;
    logic                        run_level  = 1'b0;

    reset_sequencer_change_logger_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .status_lines   (status_lines),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reset_drive    (reset_drive),
        .phase          (phase),
        .entries_logged (entries_logged),
        .entry_time     (entry_time),
        .entry_value    (entry_value)
    );

    rsc_change_log_checker log_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .status_lines   (status_lines),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reset_drive    (reset_drive),
        .phase          (phase),
        .entries_logged (entries_logged),
        .entry_time     (entry_time),
        .entry_value    (entry_value),
        .mismatches     (mismatches),
        .reports_due    (reports_due)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("reset_sequencer_change_logger_core test failed");
        $finish;
    end

    // result side: switch between randomly chosen stall patterns
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(RX_OPEN, RX_RUNS);
            mode_left  = $urandom_range(16, 128);
        end
        mode_left--;
        case (stall_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (run_left == 0)
                begin
                    run_level = ~run_level;
                    run_left  = $urandom_range(1, 12);
                end
                run_left--;
                out_ready <= run_level;
            end
        endcase
    end

    task automatic send_request(
        input op_t                    op,
        input logic [LINES_WIDTH-1:0] lines,
        input logic [INDEX_WIDTH-1:0] idx
    );
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid     <= 1'b1;
        cmd          <= op;
        status_lines <= lines;
        read_index   <= idx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
    endtask

    // hold off until every result is back, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (reports_due != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [CFG_WIDTH-1:0] hold, input logic [CFG_WIDTH-1:0] limit);
        drain();
        write_reg(CFG_RESET_HOLD, hold);
        write_reg(CFG_TIMEOUT, limit);
    endtask

    function automatic logic [CFG_WIDTH-1:0] pick_ticks(input int unsigned small_max);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_MAX;
            2:       return CFG_WIDTH'({$urandom, $urandom});
            3:       return TIMEOUT_RESET;
            default: return CFG_WIDTH'($urandom_range(1, small_max));
        endcase
    endfunction

    // mostly sequences of ticks after a start, with reads and some noise mixed in
    task automatic random_request();
        int                     roll;
        int                     pick;
        logic [INDEX_WIDTH-1:0] idx;
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        if (pick < 2)
            last_lines = LINES_READY;
        else if (pick < 5)
            last_lines = 4'($urandom_range(0, 15));
        idx = ($urandom_range(0, 3) == 0) ? INDEX_WIDTH'($urandom) :
                                            INDEX_WIDTH'($urandom_range(0, 15));
        if (roll < 7)
            send_request(OP_START, last_lines, idx);
        else if (roll < 24)
            send_request(OP_READ, 4'($urandom_range(0, 15)), idx);
        else if (roll < 27)
            send_request(OP_NOP, 4'($urandom_range(0, 15)), INDEX_WIDTH'($urandom));
        else
            send_request(OP_TICK, last_lines, idx);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default registers: zero hold, long timeout
        send_request(OP_TICK, 4'h0, '0);
        send_request(OP_READ, 4'h0, '0);
        send_request(OP_NOP, 4'hF, '1);
        send_request(OP_START, 4'hF, '0);
        send_request(OP_START, 4'h0, '0);
        send_request(OP_TICK, 4'hF, '0);
        send_request(OP_START, 4'h5, '0);
        send_request(OP_TICK, 4'h8, '0);
        send_request(OP_TICK, LINES_READY, '0);
        send_request(OP_TICK, 4'h0, '0);
        for (int i = 0; i < 6; i++)
            send_request(OP_READ, 4'h0, INDEX_WIDTH'(i));
        send_request(OP_READ, 4'h0, '1);

        // timeout of zero: times out on the first tick after release
        set_regs(40'd2, '0);
        send_request(OP_START, 4'hA, '0);
        send_request(OP_TICK, 4'hA, '0);
        send_request(OP_TICK, 4'h3, '0);
        send_request(OP_TICK, LINES_READY, '0);
        send_request(OP_READ, 4'h0, 13'd4);
        send_request(OP_START, 4'h0, '0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       set_regs(CFG_MAX, CFG_MAX);
                1:       set_regs('0, 40'd1);
                default: set_regs(pick_ticks(8), pick_ticks(30));
            endcase
            repeat (PHASE_REQUESTS) random_request();
        end

        // reset held forever, alternating lines append on every tick
        set_regs(CFG_MAX, pick_ticks(30));
        send_request(OP_START, 4'h0, '0);
        for (int i = 0; i < TOGGLE_TICKS; i++)
            send_request(OP_TICK, i[0] ? 4'h0 : 4'h1, INDEX_WIDTH'($urandom));
        send_request(OP_READ, 4'h0, '1);
        send_request(OP_READ, 4'h0, '0);
        send_request(OP_READ, 4'h0, INDEX_WIDTH'($urandom));
        send_request(OP_TICK, 4'hC, '0);
        send_request(OP_START, 4'h6, '0);
        send_request(OP_START, 4'h6, '0);
        send_request(OP_READ, 4'h0, '1);

        drain();
        if (mismatches == 0 && reports_due == 0)
            $display("reset_sequencer_change_logger_core test passed");
        else
            $display("reset_sequencer_change_logger_core test failed");
        $finish;
    end

endmodule
